[hdl/assert_macros.svh]
// Assertion helpers included by the top-level RTL file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked at every clock edge outside reset.
`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);

// Condition in one cycle implies a condition in the next.
`define ASSERT_NEXT(label, pre, post, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (pre) |=> (post)) \
        else $error(msg);

`endif

[hdl/ypld_pkg.sv]
package ypld_pkg;

    localparam int ANGLE_FRACTION_BITS  = 8;
    localparam int VECTOR_FRACTION_BITS = 14;

    localparam int QUARTER_TURN = 90 << ANGLE_FRACTION_BITS;
    localparam int FULL_TURN    = 4 * QUARTER_TURN;

    localparam int Q_BITS    = 30;
    localparam int MAG_W     = Q_BITS + 1;
    localparam int PROD_W    = 2 * MAG_W;
    localparam int MUL_CNT_W = $clog2(MAG_W + 1);

    localparam int YAW_W   = $clog2(FULL_TURN);
    localparam int PITCH_W = 16;
    localparam int TH_W    = YAW_W + 1;
    localparam int R_W     = $clog2(QUARTER_TURN + 1);

    localparam int DIV_STEPS = R_W + Q_BITS;
    localparam int DIV_CNT_W = $clog2(DIV_STEPS + 1);

    localparam int ANGLE_SHIFT = 16 - ANGLE_FRACTION_BITS;
    localparam int STEP_V_W    = 34;
    localparam int STEP_W      = STEP_V_W - ANGLE_SHIFT;
    localparam int SUM_W       = STEP_W + 1;

    localparam int WRAP_SHIFTS = 7;
    localparam int WRAP_W      = YAW_W + WRAP_SHIFTS + 1;
    localparam int WCNT_W      = $clog2(WRAP_SHIFTS + 1);

    localparam int VEC_W     = 16;
    localparam int VEC_SHIFT = 2 * Q_BITS - VECTOR_FRACTION_BITS;

    typedef logic [MAG_W-1:0]         mag_t;
    typedef logic [PROD_W-1:0]        prod_t;
    typedef logic signed [STEP_W-1:0] step_t;
    typedef logic [VEC_W-1:0]         vec_t;
    typedef logic [1:0]               ang_t;

    localparam ang_t ANG_COS_YAW   = 2'd0;
    localparam ang_t ANG_SIN_YAW   = 2'd1;
    localparam ang_t ANG_COS_PITCH = 2'd2;
    localparam ang_t ANG_SIN_PITCH = 2'd3;
    localparam int   ANG_N         = 4;

    localparam logic CFG_SENSITIVITY = 1'b0;
    localparam logic CFG_PITCH_LIMIT = 1'b1;

    localparam logic [15:0] SENS_RESET  = 16'd6554;
    localparam logic [14:0] PLIM_RESET  = 15'd22784;
    localparam vec_t        VEC_ONE     = VEC_W'(1 << VECTOR_FRACTION_BITS);
    localparam mag_t        ONE_Q30     = MAG_W'(1 << Q_BITS);

    // odd polynomial for sin(pi/2 * x), Q30, lowest order first
    localparam mag_t POLY_COEF [4] = '{
        MAG_W'(1686629713), MAG_W'(693598669), MAG_W'(85569306), MAG_W'(5026995)
    };
    localparam mag_t POLY_TOP = MAG_W'(172272);

    localparam logic signed [SUM_W-1:0] WRAP_BIAS = SUM_W'(FULL_TURN << WRAP_SHIFTS);
    localparam logic [PROD_W:0] ROUND_HALF = (PROD_W + 1)'(1) << (VEC_SHIFT - 1);

    function automatic step_t angle_step(input prod_t p, input logic neg);
        logic signed [STEP_V_W-1:0] v;
        v = signed'(STEP_V_W'(p[MAG_W-1:0]));
        if (neg) begin
            v = -v;
        end
        v = v + STEP_V_W'(1 << (ANGLE_SHIFT - 1));
        return v[STEP_V_W-1:ANGLE_SHIFT];
    endfunction

    function automatic logic [WRAP_W-1:0] wrap_modulus(input logic [WCNT_W-1:0] n);
        return WRAP_W'(FULL_TURN) << n;
    endfunction

    function automatic mag_t q30_part(input prod_t p);
        return p[Q_BITS +: MAG_W];
    endfunction

    function automatic vec_t vec_round(input prod_t p, input logic neg);
        logic [PROD_W:0] sum;
        vec_t            mag;
        sum = {1'b0, p} + ROUND_HALF;
        mag = sum[VEC_SHIFT +: VEC_W];
        return neg ? vec_t'(-mag) : mag;
    endfunction

endpackage

[hdl/ypld_mul.sv]
module ypld_mul import ypld_pkg::*; (
    input  logic  aclk,
    input  logic  aresetn,
    input  logic  start,
    input  mag_t  a,
    input  mag_t  b,
    output logic  done,
    output prod_t product
);

    mag_t                 a_reg, a_next;
    prod_t                prod_reg, prod_next;
    logic [MUL_CNT_W-1:0] cnt_reg, cnt_next;
    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;
    logic [MAG_W:0]       sum;

    always_comb begin
        sum       = {1'b0, prod_reg[PROD_W-1:MAG_W]} + (prod_reg[0] ? {1'b0, a_reg} : '0);
        a_next    = a_reg;
        prod_next = prod_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start) begin
            a_next    = a;
            prod_next = {{MAG_W{1'b0}}, b};
            cnt_next  = MUL_CNT_W'(MAG_W);
            busy_next = 1'b1;
        end else if (busy_reg) begin
            prod_next = {sum, prod_reg[MAG_W-1:1]};
            cnt_next  = cnt_reg - 1'b1;
            if (cnt_reg == MUL_CNT_W'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge aclk) begin
        a_reg    <= a_next;
        prod_reg <= prod_next;
    end

    assign done    = done_reg;
    assign product = prod_reg;

endmodule

[hdl/ypld_div.sv]
module ypld_div import ypld_pkg::*; (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           start,
    input  logic [R_W-1:0] r,
    output logic           done,
    output mag_t           quotient
);

    logic [R_W-1:0]       rem_reg, rem_next;
    logic [R_W-1:0]       num_reg, num_next;
    mag_t                 quo_reg, quo_next;
    logic [DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;
    logic [R_W:0]         trial;
    logic [R_W:0]         diff;
    logic                 fits;

    always_comb begin
        trial     = {rem_reg, num_reg[R_W-1]};
        diff      = trial - (R_W + 1)'(QUARTER_TURN);
        fits      = trial >= (R_W + 1)'(QUARTER_TURN);
        rem_next  = rem_reg;
        num_next  = num_reg;
        quo_next  = quo_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start) begin
            rem_next  = '0;
            num_next  = r;
            quo_next  = '0;
            cnt_next  = DIV_CNT_W'(DIV_STEPS);
            busy_next = 1'b1;
        end else if (busy_reg) begin
            rem_next = fits ? diff[R_W-1:0] : trial[R_W-1:0];
            num_next = {num_reg[R_W-2:0], 1'b0};
            quo_next = {quo_reg[MAG_W-2:0], fits};
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == DIV_CNT_W'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge aclk) begin
        rem_reg <= rem_next;
        num_reg <= num_next;
        quo_reg <= quo_next;
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

[hdl/yaw_pitch_look_direction.sv]
// Free-look camera: each mouse event (button flag in s_tuser, X and Y motion in s_tdata)
// gives one look vector (Q2.14 x, y, z in m_tdata) with m_tuser set when the button was held.
// While the button is held the motion is scaled by the sensitivity, yaw wraps at 360 degrees
// and pitch clamps to the pitch limit; sine and cosine come from a polynomial evaluated on
// one 31-bit shift-add multiplier (28 products per event) and a restoring divider for the
// quarter-turn mapping (four divisions per event). A released event skips the arithmetic
// and returns the stored vector. One event is in work at a time; the finished result waits
// in the output register while the next event is taken. Configuration writes are taken
// every cycle and must only be made while no event is in work.
`include "assert_macros.svh"

module yaw_pitch_look_direction import ypld_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // motion_x, motion_y
    input  logic        s_tuser,   // button_held
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata,   // look_x, look_y, look_z
    output logic        m_tuser,   // updated
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic        cfg_index,
    input  logic [15:0] cfg_data
);

    typedef enum logic [12:0] {
        ST_IDLE        = 13'b0000000000001,
        ST_STEP_X      = 13'b0000000000010,
        ST_YAW_WRAP    = 13'b0000000000100,
        ST_STEP_Y      = 13'b0000000001000,
        ST_SINE_RED    = 13'b0000000010000,
        ST_SINE_QUAD   = 13'b0000000100000,
        ST_SINE_DIV    = 13'b0000001000000,
        ST_SINE_X2     = 13'b0000010000000,
        ST_SINE_HORNER = 13'b0000100000000,
        ST_SINE_FIN    = 13'b0001000000000,
        ST_PROD_X      = 13'b0010000000000,
        ST_PROD_Z      = 13'b0100000000000,
        ST_OUT         = 13'b1000000000000
    } state_t;

    state_t                    state_reg, state_next;
    logic [15:0]               sens_reg, sens_next;
    logic [14:0]               plim_reg, plim_next;
    logic [YAW_W-1:0]          yaw_reg, yaw_next;
    logic signed [PITCH_W-1:0] pitch_reg, pitch_next;
    vec_t                      look_x_reg, look_x_next;
    vec_t                      look_y_reg, look_y_next;
    vec_t                      look_z_reg, look_z_next;
    logic                      mx_neg_reg, mx_neg_next;
    logic signed [15:0]        my_reg, my_next;
    logic [WRAP_W-1:0]         wrap_reg, wrap_next;
    logic [WCNT_W-1:0]         wcnt_reg, wcnt_next;
    ang_t                      ang_reg, ang_next;
    logic [1:0]                hidx_reg, hidx_next;
    logic [YAW_W-1:0]          th_reg, th_next;
    logic [R_W-1:0]            r_reg, r_next;
    mag_t                      x_reg, x_next;
    mag_t                      x2_reg, x2_next;
    mag_t                      sin_mag_reg [ANG_N];
    mag_t                      sin_mag_next [ANG_N];
    logic [ANG_N-1:0]          sin_neg_reg, sin_neg_next;
    logic                      upd_reg, upd_next;
    logic                      mul_go_reg, mul_go_next;
    mag_t                      op_a_reg, op_a_next;
    mag_t                      op_b_reg, op_b_next;
    logic                      div_go_reg, div_go_next;
    logic                      m_tvalid_reg, m_tvalid_next;
    logic [47:0]               m_tdata_reg, m_tdata_next;
    logic                      m_tuser_reg, m_tuser_next;

    logic                      mul_done;
    prod_t                     mul_prod;
    logic                      div_done;
    mag_t                      div_quo;

    logic [15:0]               mx_mag;
    logic [15:0]               my_mag;
    step_t                     step;
    logic signed [SUM_W-1:0]   asum;
    logic signed [SUM_W-1:0]   lim_s;
    logic [WRAP_W-1:0]         wmod;
    logic [WRAP_W-1:0]         wsub;
    logic signed [TH_W-1:0]    th;
    logic [1:0]                quad;
    logic [YAW_W-1:0]          qoff;
    logic [R_W-1:0]            rq;
    mag_t                      tnew;
    mag_t                      s_val;

    ypld_mul u_mul (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (mul_go_reg),
        .a       (op_a_reg),
        .b       (op_b_reg),
        .done    (mul_done),
        .product (mul_prod)
    );

    ypld_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_go_reg),
        .r        (r_reg),
        .done     (div_done),
        .quotient (div_quo)
    );

    always_comb begin
        state_next    = state_reg;
        sens_next     = sens_reg;
        plim_next     = plim_reg;
        yaw_next      = yaw_reg;
        pitch_next    = pitch_reg;
        look_x_next   = look_x_reg;
        look_y_next   = look_y_reg;
        look_z_next   = look_z_reg;
        mx_neg_next   = mx_neg_reg;
        my_next       = my_reg;
        wrap_next     = wrap_reg;
        wcnt_next     = wcnt_reg;
        ang_next      = ang_reg;
        hidx_next     = hidx_reg;
        th_next       = th_reg;
        r_next        = r_reg;
        x_next        = x_reg;
        x2_next       = x2_reg;
        sin_mag_next  = sin_mag_reg;
        sin_neg_next  = sin_neg_reg;
        upd_next      = upd_reg;
        mul_go_next   = 1'b0;
        op_a_next     = op_a_reg;
        op_b_next     = op_b_reg;
        div_go_next   = 1'b0;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        m_tdata_next  = m_tdata_reg;
        m_tuser_next  = m_tuser_reg;

        mx_mag = s_tdata[15] ? 16'(~s_tdata[15:0] + 16'd1) : s_tdata[15:0];
        my_mag = my_reg[15] ? 16'(~my_reg + 16'sd1) : my_reg;
        step   = angle_step(mul_prod, state_reg == ST_STEP_X ? mx_neg_reg : my_reg[15]);
        lim_s  = signed'(SUM_W'(plim_reg));
        asum   = '0;
        wmod   = wrap_modulus(wcnt_reg);
        wsub   = (wrap_reg >= wmod) ? wrap_reg - wmod : wrap_reg;
        th     = '0;
        quad   = 2'd0;
        qoff   = '0;
        rq     = '0;
        tnew   = POLY_COEF[hidx_reg] - q30_part(mul_prod);
        s_val  = (q30_part(mul_prod) > ONE_Q30) ? ONE_Q30 : q30_part(mul_prod);

        if (cfg_valid) begin
            unique case (cfg_index)
                CFG_SENSITIVITY: sens_next = cfg_data;
                CFG_PITCH_LIMIT: plim_next = cfg_data[14:0];
                default:         sens_next = sens_reg;
            endcase
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    if (s_tuser) begin
                        mx_neg_next = s_tdata[15];
                        my_next     = s_tdata[31:16];
                        op_a_next   = MAG_W'(mx_mag);
                        op_b_next   = MAG_W'(sens_reg);
                        mul_go_next = 1'b1;
                        state_next  = ST_STEP_X;
                    end else begin
                        upd_next   = 1'b0;
                        state_next = ST_OUT;
                    end
                end
            end
            ST_STEP_X: begin
                if (mul_done) begin
                    asum = signed'(SUM_W'(yaw_reg)) + SUM_W'(step);
                    if (asum < 0) begin
                        asum = asum + WRAP_BIAS;
                    end
                    wrap_next  = asum[WRAP_W-1:0];
                    wcnt_next  = WCNT_W'(WRAP_SHIFTS);
                    state_next = ST_YAW_WRAP;
                end
            end
            ST_YAW_WRAP: begin
                wrap_next = wsub;
                wcnt_next = wcnt_reg - 1'b1;
                if (wcnt_reg == '0) begin
                    yaw_next    = wsub[YAW_W-1:0];
                    op_a_next   = MAG_W'(my_mag);
                    op_b_next   = MAG_W'(sens_reg);
                    mul_go_next = 1'b1;
                    state_next  = ST_STEP_Y;
                end
            end
            ST_STEP_Y: begin
                if (mul_done) begin
                    asum = SUM_W'(pitch_reg) + SUM_W'(step);
                    if (asum > lim_s) begin
                        asum = lim_s;
                    end else if (asum < -lim_s) begin
                        asum = -lim_s;
                    end
                    pitch_next = asum[PITCH_W-1:0];
                    ang_next   = ANG_COS_YAW;
                    state_next = ST_SINE_RED;
                end
            end
            ST_SINE_RED: begin
                unique case (ang_reg)
                    ANG_COS_YAW:   th = signed'(TH_W'(yaw_reg)) + TH_W'(QUARTER_TURN);
                    ANG_SIN_YAW:   th = signed'(TH_W'(yaw_reg));
                    ANG_COS_PITCH: th = TH_W'(pitch_reg) + TH_W'(QUARTER_TURN);
                    ANG_SIN_PITCH: th = TH_W'(pitch_reg);
                    default:       th = '0;
                endcase
                if (th < 0) begin
                    th = th + TH_W'(FULL_TURN);
                end else if (th >= TH_W'(FULL_TURN)) begin
                    th = th - TH_W'(FULL_TURN);
                end
                th_next    = th[YAW_W-1:0];
                state_next = ST_SINE_QUAD;
            end
            ST_SINE_QUAD: begin
                priority if (th_reg >= YAW_W'(3 * QUARTER_TURN)) begin
                    quad = 2'd3;
                    qoff = YAW_W'(3 * QUARTER_TURN);
                end else if (th_reg >= YAW_W'(2 * QUARTER_TURN)) begin
                    quad = 2'd2;
                    qoff = YAW_W'(2 * QUARTER_TURN);
                end else if (th_reg >= YAW_W'(QUARTER_TURN)) begin
                    quad = 2'd1;
                    qoff = YAW_W'(QUARTER_TURN);
                end else begin
                    quad = 2'd0;
                    qoff = '0;
                end
                rq                    = R_W'(th_reg - qoff);
                r_next                = quad[0] ? R_W'(QUARTER_TURN) - rq : rq;
                sin_neg_next[ang_reg] = quad[1];
                div_go_next           = 1'b1;
                state_next            = ST_SINE_DIV;
            end
            ST_SINE_DIV: begin
                if (div_done) begin
                    x_next      = div_quo;
                    op_a_next   = div_quo;
                    op_b_next   = div_quo;
                    mul_go_next = 1'b1;
                    state_next  = ST_SINE_X2;
                end
            end
            ST_SINE_X2: begin
                if (mul_done) begin
                    x2_next     = q30_part(mul_prod);
                    op_a_next   = q30_part(mul_prod);
                    op_b_next   = POLY_TOP;
                    hidx_next   = 2'd3;
                    mul_go_next = 1'b1;
                    state_next  = ST_SINE_HORNER;
                end
            end
            ST_SINE_HORNER: begin
                if (mul_done) begin
                    op_b_next   = tnew;
                    mul_go_next = 1'b1;
                    if (hidx_reg == 2'd0) begin
                        op_a_next  = x_reg;
                        state_next = ST_SINE_FIN;
                    end else begin
                        op_a_next = x2_reg;
                        hidx_next = hidx_reg - 2'd1;
                    end
                end
            end
            ST_SINE_FIN: begin
                if (mul_done) begin
                    sin_mag_next[ang_reg] = s_val;
                    if (ang_reg == ANG_SIN_PITCH) begin
                        op_a_next   = sin_mag_reg[ANG_COS_YAW];
                        op_b_next   = sin_mag_reg[ANG_COS_PITCH];
                        mul_go_next = 1'b1;
                        state_next  = ST_PROD_X;
                    end else begin
                        ang_next   = ang_reg + 2'd1;
                        state_next = ST_SINE_RED;
                    end
                end
            end
            ST_PROD_X: begin
                if (mul_done) begin
                    look_x_next = vec_round(mul_prod,
                        sin_neg_reg[ANG_COS_YAW] ^ sin_neg_reg[ANG_COS_PITCH]);
                    look_y_next = vec_round(
                        prod_t'({sin_mag_reg[ANG_SIN_PITCH], {Q_BITS{1'b0}}}),
                        sin_neg_reg[ANG_SIN_PITCH]);
                    op_a_next   = sin_mag_reg[ANG_SIN_YAW];
                    op_b_next   = sin_mag_reg[ANG_COS_PITCH];
                    mul_go_next = 1'b1;
                    state_next  = ST_PROD_Z;
                end
            end
            ST_PROD_Z: begin
                if (mul_done) begin
                    look_z_next = vec_round(mul_prod,
                        sin_neg_reg[ANG_SIN_YAW] ^ sin_neg_reg[ANG_COS_PITCH]);
                    upd_next    = 1'b1;
                    state_next  = ST_OUT;
                end
            end
            ST_OUT: begin
                if (!m_tvalid_reg || m_tready) begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = {look_z_reg, look_y_reg, look_x_reg};
                    m_tuser_next  = upd_reg;
                    state_next    = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            sens_reg     <= SENS_RESET;
            plim_reg     <= PLIM_RESET;
            yaw_reg      <= '0;
            pitch_reg    <= '0;
            look_x_reg   <= VEC_ONE;
            look_y_reg   <= '0;
            look_z_reg   <= '0;
            wcnt_reg     <= '0;
            ang_reg      <= ANG_COS_YAW;
            hidx_reg     <= '0;
            mul_go_reg   <= 1'b0;
            div_go_reg   <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            sens_reg     <= sens_next;
            plim_reg     <= plim_next;
            yaw_reg      <= yaw_next;
            pitch_reg    <= pitch_next;
            look_x_reg   <= look_x_next;
            look_y_reg   <= look_y_next;
            look_z_reg   <= look_z_next;
            wcnt_reg     <= wcnt_next;
            ang_reg      <= ang_next;
            hidx_reg     <= hidx_next;
            mul_go_reg   <= mul_go_next;
            div_go_reg   <= div_go_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        mx_neg_reg  <= mx_neg_next;
        my_reg      <= my_next;
        wrap_reg    <= wrap_next;
        th_reg      <= th_next;
        r_reg       <= r_next;
        x_reg       <= x_next;
        x2_reg      <= x2_next;
        sin_mag_reg <= sin_mag_next;
        sin_neg_reg <= sin_neg_next;
        upd_reg     <= upd_next;
        op_a_reg    <= op_a_next;
        op_b_reg    <= op_b_next;
        m_tdata_reg <= m_tdata_next;
        m_tuser_reg <= m_tuser_next;
    end

    assign s_tready  = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;
    assign m_tvalid  = m_tvalid_reg;
    assign m_tdata   = m_tdata_reg;
    assign m_tuser   = m_tuser_reg;

    `ASSERT_CLK(a_yaw_wrapped, yaw_reg < YAW_W'(FULL_TURN), "yaw left the full turn")
    `ASSERT_NEXT(a_pitch_clamped, (state_reg == ST_STEP_Y) && mul_done, ($signed(pitch_reg) <= $signed({1'b0, plim_reg})) && ($signed(pitch_reg) >= -$signed({1'b0, plim_reg})), "pitch beyond limit")
    `ASSERT_CLK(a_result_from_out, $rose(m_tvalid_reg) |-> $past(state_reg == ST_OUT), "result loaded outside output state")

endmodule

[dv/tb_yaw_pitch_look_direction.sv]
`timescale 1ns / 100ps

module tb_yaw_pitch_look_direction;
    import ypld_pkg::*;

    localparam int     ANGLE_FB = 8;
    localparam int     VEC_FB   = 14;
    localparam longint QTR      = 90 << ANGLE_FB;
    localparam longint TURN     = 4 * QTR;
    localparam bit [63:0] Q30_UNIT = 64'd1 << 30;

    typedef struct packed {
        logic        upd;
        logic [15:0] z;
        logic [15:0] y;
        logic [15:0] x;
    } look_t;

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [31:0] s_tdata;   // motion_x, motion_y
    logic        s_tuser;   // button_held
    logic        m_tvalid;
    logic        m_tready;
    logic [47:0] m_tdata;   // look_x, look_y, look_z
    logic        m_tuser;   // updated
    logic        cfg_valid;
    logic        cfg_ready;
    logic        cfg_index;
    logic [15:0] cfg_data;

    logic [15:0] sens_setting;
    logic [14:0] pitch_limit_setting;
    longint      yaw_angle_q;
    longint      pitch_angle_q;
    look_t       held_look;
    look_t       expected_looks[$];
    int          mismatch_count;
    bit          steady;

    yaw_pitch_look_direction u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #4 aclk = ~aclk;

    function automatic longint scaled_step(input logic signed [15:0] motion);
        longint m;
        longint v;
        m = motion;
        v = m * longint'({48'd0, sens_setting}) + (longint'(1) << (15 - ANGLE_FB));
        return v >>> (16 - ANGLE_FB);
    endfunction

    function automatic bit [63:0] poly_sine(input bit [63:0] x);
        bit [63:0] x2;
        bit [63:0] t;
        bit [63:0] s;
        x2 = (x * x) >> 30;
        t = 64'd172272;
        t = 64'd5026995 - ((x2 * t) >> 30);
        t = 64'd85569306 - ((x2 * t) >> 30);
        t = 64'd693598669 - ((x2 * t) >> 30);
        t = 64'd1686629713 - ((x2 * t) >> 30);
        s = (x * t) >> 30;
        return (s > Q30_UNIT) ? Q30_UNIT : s;
    endfunction

    function automatic longint signed_sine(input longint theta);
        longint    th;
        longint    q;
        longint    r;
        bit [63:0] s;
        th = theta % TURN;
        if (th < 0) begin
            th = th + TURN;
        end
        q = th / QTR;
        r = th % QTR;
        if ((q % 2) == 1) begin
            r = QTR - r;
        end
        s = poly_sine((64'(r) << 30) / 64'(QTR));
        return (q >= 2) ? -$signed(s) : $signed(s);
    endfunction

    function automatic bit [63:0] abs_q30(input longint v);
        return (v < 0) ? 64'(-v) : 64'(v);
    endfunction

    function automatic logic [15:0] round_component(input bit [63:0] mag, input bit neg,
                                                    input int shift);
        bit [63:0] r;
        r = (mag + (64'd1 << (shift - 1))) >> shift;
        if (neg) begin
            r = -r;
        end
        return r[15:0];
    endfunction

    function automatic look_t advance_camera(input bit held, input logic signed [15:0] mx,
                                             input logic signed [15:0] my);
        longint lim;
        longint cy;
        longint sy;
        longint cp;
        longint sp;
        if (held) begin
            lim = longint'({49'd0, pitch_limit_setting});
            yaw_angle_q = (yaw_angle_q + scaled_step(mx)) % TURN;
            if (yaw_angle_q < 0) begin
                yaw_angle_q = yaw_angle_q + TURN;
            end
            pitch_angle_q = pitch_angle_q + scaled_step(my);
            if (pitch_angle_q > lim) begin
                pitch_angle_q = lim;
            end
            if (pitch_angle_q < -lim) begin
                pitch_angle_q = -lim;
            end
            cy = signed_sine(yaw_angle_q + QTR);
            sy = signed_sine(yaw_angle_q);
            cp = signed_sine(pitch_angle_q + QTR);
            sp = signed_sine(pitch_angle_q);
            held_look.x = round_component(abs_q30(cy) * abs_q30(cp), (cy < 0) != (cp < 0),
                                          60 - VEC_FB);
            held_look.y = round_component(abs_q30(sp), sp < 0, 30 - VEC_FB);
            held_look.z = round_component(abs_q30(sy) * abs_q30(cp), (sy < 0) != (cp < 0),
                                          60 - VEC_FB);
        end
        held_look.upd = held;
        return held_look;
    endfunction

    function automatic logic [15:0] pick_motion();
        int sel;
        sel = $urandom_range(9);
        if (sel < 4) begin
            return 16'(int'($urandom_range(400)) - 200);
        end else if (sel < 7) begin
            return 16'(int'($urandom_range(8000)) - 4000);
        end
        return 16'($urandom);
    endfunction

    task automatic flag_error(input string msg);
        mismatch_count = mismatch_count + 1;
        if (mismatch_count <= 10) begin
            $display("[%0t] mismatch: %s", $realtime, msg);
        end
    endtask

    task automatic send_event(input bit held, input logic [15:0] mx, input logic [15:0] my);
        @(negedge aclk);
        while (!steady && $urandom_range(99) < 33) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= held;
        s_tdata  <= {my, mx};
        do @(posedge aclk); while (!s_tready);
        expected_looks.push_back(advance_camera(held, mx, my));
    endtask

    task automatic drain_events(input int settle);
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (expected_looks.size() != 0) @(posedge aclk);
        repeat (settle) @(posedge aclk);
    endtask

    task automatic write_register(input logic idx, input logic [15:0] value);
        drain_events(8);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do @(posedge aclk); while (!cfg_ready);
        if (idx == CFG_SENSITIVITY) begin
            sens_setting = value;
        end else begin
            pitch_limit_setting = value[14:0];
        end
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    task automatic test_reset_state();
        send_event(1'b0, 16'sd0, 16'sd0);
        send_event(1'b1, 16'sd0, 16'sd0);
        send_event(1'b0, 16'sh7fff, 16'sh8000);
    endtask

    task automatic test_motion_extremes();
        send_event(1'b1, 16'sh7fff, 16'sd0);
        send_event(1'b1, 16'sh8000, 16'sd0);
        send_event(1'b1, 16'sd0, 16'sh7fff);
        send_event(1'b1, 16'sd0, 16'sh8000);
        send_event(1'b1, 16'shffff, 16'shffff);
        send_event(1'b0, 16'sh8000, 16'sh7fff);
        send_event(1'b1, 16'sh7fff, 16'sh7fff);
    endtask

    task automatic test_rounding_ties();
        write_register(CFG_SENSITIVITY, 16'd128);
        send_event(1'b1, 16'sd1, 16'sd1);
        send_event(1'b1, -16'sd1, -16'sd1);
        send_event(1'b1, 16'sd3, 16'sd3);
        send_event(1'b1, -16'sd3, -16'sd3);
    endtask

    task automatic test_pitch_limits();
        write_register(CFG_SENSITIVITY, 16'hffff);
        write_register(CFG_PITCH_LIMIT, 16'd0);
        send_event(1'b1, 16'sd300, 16'sd1000);
        write_register(CFG_PITCH_LIMIT, 16'd23040);
        send_event(1'b1, 16'sd0, 16'sh7fff);
        send_event(1'b1, 16'sd0, 16'sh8000);
        write_register(CFG_PITCH_LIMIT, 16'h7fff);
        send_event(1'b1, -16'sd77, 16'sh7fff);
        write_register(CFG_SENSITIVITY, 16'd0);
        send_event(1'b1, 16'sd1234, -16'sd999);
        send_event(1'b0, 16'sd0, 16'sd0);
    endtask

    task automatic test_yaw_wrap();
        write_register(CFG_SENSITIVITY, 16'hffff);
        write_register(CFG_PITCH_LIMIT, 16'd11520);
        send_event(1'b1, 16'sh7fff, 16'sd5);
        send_event(1'b1, 16'sh7fff, -16'sd5);
        send_event(1'b1, 16'sh8000, 16'sd0);
        send_event(1'b1, -16'sd359, 16'sd0);
    endtask

    task automatic test_random_settings();
        logic [15:0] sens;
        logic [15:0] lim;
        for (int phase = 0; phase < 6; phase++) begin
            case (phase)
                0: begin sens = 16'd6554; lim = 16'd22784; end
                1: begin sens = 16'hffff; lim = 16'd23040; end
                2: begin sens = 16'($urandom); lim = 16'($urandom_range(23040)); end
                3: begin sens = 16'($urandom_range(300, 1)); lim = 16'h7fff; end
                4: begin sens = 16'($urandom); lim = 16'($urandom) | 16'h8000; end
                default: begin sens = 16'($urandom); lim = 16'($urandom_range(23040)); end
            endcase
            write_register(CFG_SENSITIVITY, sens);
            write_register(CFG_PITCH_LIMIT, lim);
            steady = (phase == 2);
            repeat (300) begin
                send_event($urandom_range(99) < 65, pick_motion(), pick_motion());
            end
            steady = 1'b0;
        end
    endtask

    always @(negedge aclk) begin
        m_tready <= aresetn && (steady || $urandom_range(99) >= 33);
    end

    always @(posedge aclk) begin : check_look
        look_t seen;
        look_t want;
        if (aresetn && m_tvalid && m_tready) begin
            seen.x   = m_tdata[15:0];
            seen.y   = m_tdata[31:16];
            seen.z   = m_tdata[47:32];
            seen.upd = m_tuser;
            if (expected_looks.size() == 0) begin
                flag_error($sformatf("unexpected look vector %h updated %b", m_tdata, m_tuser));
            end else begin
                want = expected_looks.pop_front();
                if (want.x !== seen.x)
                    flag_error($sformatf("look_x exp %0d got %0d",
                                         $signed(want.x), $signed(seen.x)));
                if (want.y !== seen.y)
                    flag_error($sformatf("look_y exp %0d got %0d",
                                         $signed(want.y), $signed(seen.y)));
                if (want.z !== seen.z)
                    flag_error($sformatf("look_z exp %0d got %0d",
                                         $signed(want.z), $signed(seen.z)));
                if (want.upd !== seen.upd)
                    flag_error($sformatf("updated exp %b got %b", want.upd, seen.upd));
            end
        end
    end

    initial begin
        aclk      = 1'b0;
        aresetn   = 1'b0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        s_tuser   = 1'b0;
        m_tready  = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = CFG_SENSITIVITY;
        cfg_data  = '0;
        steady    = 1'b0;
        mismatch_count      = 0;
        sens_setting        = 16'd6554;
        pitch_limit_setting = 15'd22784;
        yaw_angle_q         = 0;
        pitch_angle_q       = 0;
        held_look           = '{upd: 1'b0, z: 16'd0, y: 16'd0, x: 16'd16384};
        repeat (12) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        test_reset_state();
        test_motion_extremes();
        test_rounding_ties();
        test_pitch_limits();
        test_yaw_wrap();
        test_random_settings();

        drain_events(40);
        if (expected_looks.size() != 0) begin
            flag_error($sformatf("%0d look vectors never arrived", expected_looks.size()));
        end
        if (mismatch_count == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

    initial begin
        #(80_000_000);
        $display("RESULT: ERROR");
        $finish;
    end

endmodule

[yaw_pitch_look_direction.f]
+incdir+hdl
hdl/ypld_pkg.sv
hdl/ypld_mul.sv
hdl/ypld_div.sv
hdl/yaw_pitch_look_direction.sv
dv/tb_yaw_pitch_look_direction.sv
